### rtl/core/rht_pkg.sv
`default_nettype none

package rht_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int HANDLE_LIMIT  = (TABLE_ENTRIES < 256) ? TABLE_ENTRIES : 256;
    localparam int IDX_W         = $clog2(HANDLE_LIMIT);

    localparam int MODE_W   = 3;
    localparam int HANDLE_W = 8;
    localparam int SIZE_W   = 16;
    localparam int USERS_W  = 16;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [USERS_W-1:0]  t_users;
    typedef logic [IDX_W-1:0]    t_idx;

    localparam t_mode MODE_ALLOC   = 3'd0;
    localparam t_mode MODE_QUERY   = 3'd1;
    localparam t_mode MODE_ACCESS  = 3'd2;
    localparam t_mode MODE_RELEASE = 3'd3;
    localparam t_mode MODE_UNLOCK  = 3'd4;
    localparam t_mode MODE_CLEAR   = 3'd5;

    localparam t_users USERS_MAX = '1;

    typedef struct packed {
        t_size  size;
        t_users users;
        logic   locked;
        logic   untouched;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OPEN,
        ST_OP,
        ST_DONE
    } t_state;

    function automatic logic entry_free(t_entry e);
        return !e.locked && (e.users == '0) && !e.untouched;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rht_req_if.sv
`default_nettype none

interface rht_req_if;
    import rht_pkg::*;

    logic    valid;
    logic    ready;
    t_mode   mode;
    t_handle handle;
    t_size   payload_size;

    modport source (output valid, output mode, output handle, output payload_size,
                    input ready);
    modport sink   (input valid, input mode, input handle, input payload_size,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/rht_rsp_if.sv
`default_nettype none

interface rht_rsp_if;
    import rht_pkg::*;

    logic    valid;
    logic    ready;
    t_handle result_handle;
    logic    ok;

    modport source (output valid, output result_handle, output ok, input ready);
    modport sink   (input valid, input result_handle, input ok, output ready);
endinterface

`default_nettype wire

### rtl/core/refcounted_handle_table.sv
`default_nettype none
// Channel  Dir  Fields                        Handshake
// i_req    in   mode, handle, payload_size    valid/ready
// o_rsp    out  result_handle, ok             valid/ready
//
// Query, access, release, unlock: ST_OP, then ST_DONE to the response register; an invalid
// handle, clear and unknown mode go straight to ST_DONE. Allocate: ST_SCAN (none on an empty
// table), one entry checked per cycle through the single read port, then ST_OPEN if no match.
// One request at a time; a new request is taken while the previous response waits.
// Reset clears present flags and highest handle at once; no clearing pass.
// A stalled response holds the sequencer in its final state until the slot frees.

module refcounted_handle_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rht_req_if.sink    i_req,
    rht_rsp_if.source  o_rsp
);
    import rht_pkg::*;

    t_state                  r_state, n_state;
    t_mode                   r_mode, n_mode;
    t_size                   r_size, n_size;
    t_idx                    r_idx, n_idx;
    t_idx                    r_scan, n_scan;
    logic                    r_issue_done, n_issue_done;
    logic                    r_chk_v, n_chk_v;
    t_idx                    r_chk_idx, n_chk_idx;
    logic                    r_chk_pres, n_chk_pres;
    logic                    r_gap_v, n_gap_v;
    t_idx                    r_gap_idx, n_gap_idx;
    t_handle                 r_res_handle, n_res_handle;
    logic                    r_res_ok, n_res_ok;
    logic [HANDLE_LIMIT-1:0] r_present, n_present;
    t_idx                    r_highest, n_highest;
    logic                    r_out_valid, n_out_valid;
    t_handle                 r_out_handle, n_out_handle;
    logic                    r_out_ok, n_out_ok;

    t_entry r_mem [HANDLE_LIMIT];
    t_entry r_rd_data;
    t_idx   rd_addr;
    logic   mem_we;
    t_idx   mem_wa;
    t_entry mem_wd;

    logic   in_ready;
    t_idx   req_idx;
    logic   req_live;
    t_idx   open_idx;
    logic   open_ok;

    assign req_idx  = i_req.handle[IDX_W-1:0];
    assign req_live = (i_req.handle != '0) && (i_req.handle <= HANDLE_W'(r_highest))
                      && r_present[req_idx];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_size       = r_size;
        n_idx        = r_idx;
        n_scan       = r_scan;
        n_issue_done = r_issue_done;
        n_chk_v      = r_chk_v;
        n_chk_idx    = r_chk_idx;
        n_chk_pres   = r_chk_pres;
        n_gap_v      = r_gap_v;
        n_gap_idx    = r_gap_idx;
        n_res_handle = r_res_handle;
        n_res_ok     = r_res_ok;
        n_present    = r_present;
        n_highest    = r_highest;
        n_out_valid  = r_out_valid;
        n_out_handle = r_out_handle;
        n_out_ok     = r_out_ok;
        in_ready     = 1'b0;
        rd_addr      = r_scan;
        mem_we       = 1'b0;
        mem_wa       = r_chk_idx;
        mem_wd       = r_rd_data;
        open_idx     = r_gap_idx;
        open_ok      = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_addr  = req_idx;
                if (i_req.valid) begin
                    n_mode       = i_req.mode;
                    n_size       = i_req.payload_size;
                    n_idx        = req_idx;
                    n_res_handle = '0;
                    n_res_ok     = 1'b0;
                    n_state      = ST_DONE;
                    unique case (i_req.mode)
                        MODE_ALLOC: begin
                            n_scan       = t_idx'(1);
                            n_issue_done = 1'b0;
                            n_chk_v      = 1'b0;
                            n_gap_v      = 1'b0;
                            n_state      = (r_highest == '0) ? ST_OPEN : ST_SCAN;
                        end
                        MODE_QUERY, MODE_ACCESS, MODE_RELEASE, MODE_UNLOCK: begin
                            if (req_live) begin
                                n_state = ST_OP;
                            end
                        end
                        MODE_CLEAR: begin
                            n_present = '0;
                            n_highest = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                n_chk_v    = !r_issue_done;
                n_chk_idx  = r_scan;
                n_chk_pres = r_present[r_scan];
                if (!r_issue_done) begin
                    if (r_scan == r_highest) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_scan = r_scan + 1'b1;
                    end
                end
                if (r_chk_v) begin
                    if (r_chk_pres && (r_rd_data.size == r_size) && entry_free(r_rd_data)) begin
                        mem_we           = 1'b1;
                        mem_wa           = r_chk_idx;
                        mem_wd.size      = r_size;
                        mem_wd.users     = '0;
                        mem_wd.locked    = 1'b1;
                        mem_wd.untouched = 1'b1;
                        n_res_handle     = HANDLE_W'(r_chk_idx);
                        n_res_ok         = 1'b1;
                        n_chk_v          = 1'b0;
                        n_state          = ST_DONE;
                    end else if (!r_chk_pres && !r_gap_v) begin
                        n_gap_v   = 1'b1;
                        n_gap_idx = r_chk_idx;
                    end
                end else if (r_issue_done) begin
                    n_state = ST_OPEN;
                end
            end
            ST_OPEN: begin
                if (r_gap_v) begin
                    open_idx = r_gap_idx;
                    open_ok  = 1'b1;
                end else if (r_highest != t_idx'(HANDLE_LIMIT - 1)) begin
                    open_idx  = r_highest + 1'b1;
                    open_ok   = 1'b1;
                    n_highest = open_idx;
                end
                if (open_ok) begin
                    mem_we              = 1'b1;
                    mem_wa              = open_idx;
                    mem_wd.size         = r_size;
                    mem_wd.users        = '0;
                    mem_wd.locked       = 1'b1;
                    mem_wd.untouched    = 1'b1;
                    n_present[open_idx] = 1'b1;
                    n_res_handle        = HANDLE_W'(open_idx);
                    n_res_ok            = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_OP: begin
                if (!entry_free(r_rd_data)) begin
                    n_res_handle = HANDLE_W'(r_idx);
                    n_res_ok     = 1'b1;
                    mem_we       = 1'b1;
                    mem_wa       = r_idx;
                    unique case (r_mode)
                        MODE_ACCESS: begin
                            if (r_rd_data.users != USERS_MAX) begin
                                mem_wd.users = r_rd_data.users + 1'b1;
                            end
                            mem_wd.untouched = 1'b0;
                        end
                        MODE_RELEASE: begin
                            if (r_rd_data.users != '0) begin
                                mem_wd.users = r_rd_data.users - 1'b1;
                            end
                        end
                        MODE_UNLOCK: begin
                            mem_wd.locked = 1'b0;
                        end
                        default: ;
                    endcase
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_handle = r_res_handle;
                    n_out_ok     = r_res_ok;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_present   <= '0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_highest   <= n_highest;
            r_out_valid <= n_out_valid;
            r_chk_v     <= n_chk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_scan       <= n_scan;
        r_issue_done <= n_issue_done;
        r_chk_idx    <= n_chk_idx;
        r_chk_pres   <= n_chk_pres;
        r_gap_v      <= n_gap_v;
        r_gap_idx    <= n_gap_idx;
        r_res_handle <= n_res_handle;
        r_res_ok     <= n_res_ok;
        r_out_handle <= n_out_handle;
        r_out_ok     <= n_out_ok;
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_handle = r_out_handle;
    assign o_rsp.ok            = r_out_ok;

    a_highest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_highest} <= (IDX_W + 1)'(HANDLE_LIMIT - 1))
        else $error("highest handle beyond table");

    a_handle_zero_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_present[0])
        else $error("handle 0 marked present");

    a_ok_matches_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ok == (r_out_handle != '0)))
        else $error("ok flag disagrees with result handle");

endmodule

`default_nettype wire
